FILE: sv/cyrillic_byte_to_utf8_assert.svh
// Assertion macros for the Cyrillic-to-UTF-8 block.
// Both macros sample on clk and are switched off while rst is high.
`ifndef CYRILLIC_BYTE_TO_UTF8_ASSERT_SVH
`define CYRILLIC_BYTE_TO_UTF8_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge.
`define CB2U_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cb2u assertion failed: invariant");

// Check that a trigger in one cycle implies a consequence in the next.
`define CB2U_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("cb2u assertion failed: sequence");

`else

`define CB2U_ASSERT_ALWAYS(lbl, cond)
`define CB2U_ASSERT_NEXT(lbl, trig, cons)

`endif

`endif

FILE: sv/cb2u_pkg.sv
package cb2u_pkg;

  // Charset selector codes.
  localparam logic [1:0] ENC_CP1251   = 2'd0;
  localparam logic [1:0] ENC_KOI8R    = 2'd1;
  localparam logic [1:0] ENC_ISO88595 = 2'd2;

  localparam int unsigned ENC_W  = 2;
  localparam int unsigned LO_W   = 7;
  localparam int unsigned ADDR_W = ENC_W + LO_W;
  // Entry holds code point minus U+0400; zero marks an unmapped byte.
  localparam int unsigned OFF_W  = 7;

  localparam logic [OFF_W-1:0] OFF_YO_UPPER = 7'h01;
  localparam logic [OFF_W-1:0] OFF_YO_LOWER = 7'h51;
  localparam logic [OFF_W-1:0] OFF_A_UPPER  = 7'h10;
  localparam logic [OFF_W-1:0] OFF_A_LOWER  = 7'h30;
  localparam logic [OFF_W-1:0] OFF_NONE     = 7'h00;

  // Lead byte is 0xD0 or 0xD1: upper seven bits fixed.
  localparam logic [6:0] UTF8_LEAD_HI = 7'h68;
  // Continuation byte marker 0b10.
  localparam logic [1:0] UTF8_CONT    = 2'b10;
  localparam logic [7:0] BYTE_UNMAPPED = 8'h00;

  // KOI8-R letters in code order, as offset from capital A.
  localparam logic [4:0] KOI_OFFSET [32] = '{
    5'd30, 5'd0,  5'd1,  5'd22, 5'd4,  5'd5,  5'd20, 5'd3,
    5'd21, 5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
    5'd15, 5'd31, 5'd16, 5'd17, 5'd18, 5'd19, 5'd6,  5'd2,
    5'd28, 5'd27, 5'd7,  5'd24, 5'd29, 5'd25, 5'd23, 5'd26
  };

  // Map a high byte (bit 7 implied) to its code point offset.
  function automatic logic [OFF_W-1:0] lut(logic [ENC_W-1:0] enc, logic [LO_W-1:0] lo);
    logic [7:0]       b;
    logic [7:0]       d;
    logic [OFF_W-1:0] off;
    b   = {1'b1, lo};
    d   = b - 8'hB0;
    off = OFF_NONE;
    unique case (enc)
      ENC_CP1251: begin
        if (b == 8'hA8)      off = OFF_YO_UPPER;
        else if (b == 8'hB8) off = OFF_YO_LOWER;
        else if (b >= 8'hC0) off = OFF_A_UPPER + {1'b0, b[5:0]};
      end
      ENC_KOI8R: begin
        if (b == 8'hB3)      off = OFF_YO_UPPER;
        else if (b == 8'hA3) off = OFF_YO_LOWER;
        else if (b >= 8'hE0) off = OFF_A_UPPER + {2'b00, KOI_OFFSET[b[4:0]]};
        else if (b >= 8'hC0) off = OFF_A_LOWER + {2'b00, KOI_OFFSET[b[4:0]]};
      end
      ENC_ISO88595: begin
        if (b == 8'hA1)      off = OFF_YO_UPPER;
        else if (b == 8'hF1) off = OFF_YO_LOWER;
        else if (b >= 8'hB0 && b <= 8'hEF) off = OFF_A_UPPER + {1'b0, d[5:0]};
      end
      default: off = OFF_NONE;
    endcase
    return off;
  endfunction

endpackage

FILE: sv/cb2u_rom.sv
module cb2u_rom (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [cb2u_pkg::ADDR_W-1:0]  rd_addr,
  output logic [cb2u_pkg::OFF_W-1:0]   rd_data
);

  // Synchronous read: address {charset, byte[6:0]}, data valid next cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= cb2u_pkg::lut(rd_addr[cb2u_pkg::ADDR_W-1:cb2u_pkg::LO_W],
                               rd_addr[cb2u_pkg::LO_W-1:0]);
    end
  end

endmodule

FILE: sv/cyrillic_byte_to_utf8.sv
// Cyrillic single-byte text to UTF-8 converter.
// Input channel: in_valid / in_stall with byte_in. One request is one byte of
//   CP-1251, KOI8-R or ISO-8859-5 text, picked by the source_encoding register.
// Output channel: out_valid / out_stall with byte_out and last_of_run. ASCII
//   bytes pass as one request; mapped letters give two requests (lead 0xD0 or
//   0xD1, then continuation); unmapped high bytes give one 0x00 request.
//   last_of_run marks the final output request of each input byte.
// Config channel: source_encoding_valid / source_encoding_ready with
//   source_encoding; always ready, write only while the block is idle.
// Path: an accepted byte is registered in the lookup stage while the ROM is
//   read; it moves into the output stage once that stage is empty or
//   finishing its request, and the output stage presents the output bytes.
// Throughput: one input byte per cycle for single-byte results while out_stall
//   is low; a letter holds the output stage until the one-byte output port has taken both of its bytes.
// Stalls: out_stall holds the output stage; the lookup stage in front of it
//   still takes one more byte, then in_stall rises until the output drains.
// Reset: rst (synchronous, active high) empties both stages and selects
//   CP-1251.
module cyrillic_byte_to_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] byte_out,
  output logic       last_of_run,
  input  logic       source_encoding_valid,
  output logic       source_encoding_ready,
  input  logic [1:0] source_encoding
);

  logic [cb2u_pkg::ENC_W-1:0] enc;

  // Lookup stage: raw byte waits here while the ROM data comes out.
  logic                       a_valid;
  logic [7:0]                 a_byte;
  logic [cb2u_pkg::OFF_W-1:0] rom_q;

  // Output stage: up to two bytes per request.
  logic       b_valid;
  logic [7:0] b_first;
  logic [7:0] b_second;
  logic       b_two;
  logic       b_phase;

  logic       in_accept;
  logic       b_done;
  logic       a_move;
  logic       a_mapped;

  assign source_encoding_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enc <= cb2u_pkg::ENC_CP1251;
    end else if (source_encoding_valid && source_encoding_ready) begin
      enc <= source_encoding;
    end
  end

  // Output stage finishes its request when the last byte is taken.
  assign b_done    = b_valid && !out_stall && (!b_two || b_phase);
  assign a_move    = a_valid && (!b_valid || b_done);
  assign in_stall  = a_valid && !a_move;
  assign in_accept = in_valid && !in_stall;

  cb2u_rom u_rom (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr ({enc, byte_in[cb2u_pkg::LO_W-1:0]}),
    .rd_data (rom_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_byte <= byte_in;
    end
  end

  assign a_mapped = a_byte[7] && (rom_q != cb2u_pkg::OFF_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_phase <= 1'b0;
    end else if (a_move) begin
      b_valid <= 1'b1;
      b_phase <= 1'b0;
    end else if (b_done) begin
      b_valid <= 1'b0;
      b_phase <= 1'b0;
    end else if (b_valid && !out_stall) begin
      // Lead byte taken; advance to the continuation byte.
      b_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_two    <= a_mapped;
      b_second <= {cb2u_pkg::UTF8_CONT, rom_q[5:0]};
      if (a_mapped) begin
        b_first <= {cb2u_pkg::UTF8_LEAD_HI, rom_q[6]};
      end else if (a_byte[7]) begin
        b_first <= cb2u_pkg::BYTE_UNMAPPED;
      end else begin
        b_first <= a_byte;
      end
    end
  end

  assign out_valid   = b_valid;
  assign byte_out    = b_phase ? b_second : b_first;
  assign last_of_run = !b_two || b_phase;

`include "cyrillic_byte_to_utf8_assert.svh"

  `CB2U_ASSERT_ALWAYS(a_phase_needs_pair, !b_phase || (b_valid && b_two))
  `CB2U_ASSERT_ALWAYS(a_lead_byte_range, !(b_valid && b_two) || b_first[7:1] == 7'h68)
  `CB2U_ASSERT_NEXT(a_lead_then_cont, b_valid && b_two && !b_phase && !out_stall, b_valid && b_phase)
  `CB2U_ASSERT_NEXT(a_accept_fills_lookup, in_accept, a_valid)

endmodule
